@@ rtl/egg_pkg.sv @@
// ---------------------------------------------------------------------------
// egg_pkg
// Shared sizes, types and state codes for the egg drop trial-count engine.
// ---------------------------------------------------------------------------
`default_nettype none

package egg_pkg;

   // Table size limits.
   localparam int MAX_EGGS   = 8;
   localparam int MAX_FLOORS = 255;

   // Field widths of the query and the answer.
   localparam int IN_BALLS_W  = 4;
   localparam int IN_FLOORS_W = 8;
   localparam int DATA_W      = 8;
   localparam int BEST_W      = DATA_W + 1;

   // Table geometry: a row per ball count, a power-of-two row length.
   localparam int EGG_W     = $clog2(MAX_EGGS + 1);
   localparam int FLOOR_W   = $clog2(MAX_FLOORS + 1);
   localparam int ROW_LEN   = 1 << FLOOR_W;
   localparam int TBL_DEPTH = (MAX_EGGS + 1) * ROW_LEN;
   localparam int ADDR_W    = EGG_W + FLOOR_W;

   typedef logic [EGG_W-1:0]   row_type;
   typedef logic [FLOOR_W-1:0] col_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [DATA_W-1:0]  entry_type;
   typedef logic [BEST_W-1:0]  best_type;

   // Table write port bundle.
   typedef struct packed {
      logic      en;
      addr_type  addr;
      entry_type data;
   } ram_wr_type;

   // Table read port bundle.
   typedef struct packed {
      logic     en;
      addr_type addr;
   } ram_rd_type;

   // Control of the running minimum.
   typedef struct packed {
      logic clear;
      logic fold;
   } fold_ctrl_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL_C0,
      ST_FILL_C1,
      ST_FILL_R1,
      ST_SCAN,
      ST_DRAIN,
      ST_FINAL,
      ST_FREAD
   } state_type;

   // Flat table address of row r, column c.
   function automatic addr_type tbl_addr(row_type r, col_type c);
      return {r, c};
   endfunction

endpackage

`default_nettype wire

@@ rtl/egg_drop_min_trials_dp.sv @@
// The inner scan makes one trial-floor table read per cycle.
// Throughput: one query at a time; the next beat is taken once the answer
// sits in the output register, while that answer may still wait there.
// Reset clears the sequencer and output valid; every table entry is written before read.
// ---------------------------------------------------------------------------
// egg_drop_min_trials_dp
// Least worst-case number of drops for the egg dropping puzzle, computed by
// dynamic programming over a table held in two mirrored memories.
// ---------------------------------------------------------------------------
`default_nettype none

module egg_drop_min_trials_dp
   import egg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [IN_BALLS_W-1:0]  req_balls,
   input  wire logic [IN_FLOORS_W-1:0] req_floors,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [DATA_W-1:0]           rsp_trials
);

   ram_wr_type    ram_wr;
   ram_rd_type    ram_rd_a;
   ram_rd_type    ram_rd_b;
   entry_type     ram_data_a;
   entry_type     ram_data_b;
   fold_ctrl_type fold_ctrl;
   entry_type     fold_best;

   // Sequencer.
   egg_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_balls     (req_balls),
      .req_floors    (req_floors),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_trials    (rsp_trials),
      .ram_wr        (ram_wr),
      .ram_rd_a      (ram_rd_a),
      .ram_rd_b      (ram_rd_b),
      .ram_data_a    (ram_data_a),
      .fold_ctrl     (fold_ctrl),
      .fold_best     (fold_best)
   );

   // Table copy read for the broken-ball outcome and the answer.
   egg_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TBL_DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd_a.en),
      .rd_addr (ram_rd_a.addr),
      .rd_data (ram_data_a)
   );

   // Table copy read for the intact-ball outcome.
   egg_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TBL_DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd_b.en),
      .rd_addr (ram_rd_b.addr),
      .rd_data (ram_data_b)
   );

   // Running minimum over trial floors.
   egg_fold u_fold (
      .clock      (clock),
      .ctrl       (fold_ctrl),
      .broke_data (ram_data_a),
      .held_data  (ram_data_b),
      .best_out   (fold_best)
   );

endmodule

`default_nettype wire

@@ rtl/egg_ram.sv @@
// ---------------------------------------------------------------------------
// egg_ram
// Generic single-write, single-read memory with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module egg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/egg_fold.sv @@
// ---------------------------------------------------------------------------
// egg_fold
// Worst-case drop count of one trial floor and the running minimum over
// all trial floors of one table entry.
// ---------------------------------------------------------------------------
`default_nettype none

module egg_fold
   import egg_pkg::*;
(
   input  wire logic          clock,
   input  wire fold_ctrl_type ctrl,
   input  wire entry_type     broke_data,
   input  wire entry_type     held_data,
   output entry_type          best_out
);

   best_type best_ff;
   best_type best_in;
   best_type worst;
   best_type folded;

   // One drop plus the worse of the two outcomes.
   always_comb begin
      if (broke_data > held_data) begin
         worst = best_type'(broke_data) + best_type'(1);
      end else begin
         worst = best_type'(held_data) + best_type'(1);
      end
      if (ctrl.fold && (worst < best_ff)) begin
         folded = worst;
      end else begin
         folded = best_ff;
      end
      if (ctrl.clear) begin
         best_in = '1;
      end else begin
         best_in = folded;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign best_out = folded[DATA_W-1:0];

endmodule

`default_nettype wire

@@ rtl/egg_seq.sv @@
// ---------------------------------------------------------------------------
// egg_seq
// Query sequencer: fills the base row and columns, walks every inner
// entry and trial floor, and returns the answer through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module egg_seq
   import egg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [IN_BALLS_W-1:0]  req_balls,
   input  wire logic [IN_FLOORS_W-1:0] req_floors,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [DATA_W-1:0]           rsp_trials,
   output ram_wr_type                  ram_wr,
   output ram_rd_type                  ram_rd_a,
   output ram_rd_type                  ram_rd_b,
   input  wire entry_type              ram_data_a,
   output fold_ctrl_type               fold_ctrl,
   input  wire entry_type              fold_best
);

   state_type state_ff, state_in;
   row_type   nb_ff, nb_in;
   col_type   nf_ff, nf_in;
   row_type   row_ff, row_in;
   col_type   col_ff, col_in;
   col_type   brk_ff, brk_in;
   col_type   held_ff, held_in;
   logic      zero_ff, zero_in;
   logic      rd_vld_ff, rd_vld_in;
   logic      rsp_valid_ff, rsp_valid_in;
   entry_type rsp_data_ff, rsp_data_in;
   row_type   nb_clamp;
   col_type   nf_clamp;
   logic      out_free;

   // Clamp the query to the table size.
   always_comb begin
      if (32'(req_balls) > MAX_EGGS) begin
         nb_clamp = row_type'(MAX_EGGS);
      end else begin
         nb_clamp = row_type'(req_balls);
      end
      if (32'(req_floors) > MAX_FLOORS) begin
         nf_clamp = col_type'(MAX_FLOORS);
      end else begin
         nf_clamp = col_type'(req_floors);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state, counters, table accesses and result beat.
   always_comb begin
      state_in     = state_ff;
      nb_in        = nb_ff;
      nf_in        = nf_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      brk_in       = brk_ff;
      held_in      = held_ff;
      zero_in      = zero_ff;
      rd_vld_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_wr       = '0;
      ram_rd_a     = '0;
      ram_rd_b     = '0;
      fold_ctrl    = '0;
      req_stall    = 1'b1;

      fold_ctrl.fold = rd_vld_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               nb_in   = nb_clamp;
               nf_in   = nf_clamp;
               row_in  = row_type'(1);
               zero_in = (nb_clamp == '0);
               if (nb_clamp == '0) begin
                  state_in = ST_FREAD;
               end else begin
                  state_in = ST_FILL_C0;
               end
            end
         end

         // Column zero of every used row holds zero.
         ST_FILL_C0: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = tbl_addr(row_ff, '0);
            ram_wr.data = '0;
            if (row_ff == nb_ff) begin
               row_in = row_type'(1);
               if (nf_ff == '0) begin
                  state_in = ST_FINAL;
               end else begin
                  state_in = ST_FILL_C1;
               end
            end else begin
               row_in = row_ff + row_type'(1);
            end
         end

         // Column one of every used row holds one.
         ST_FILL_C1: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = tbl_addr(row_ff, col_type'(1));
            ram_wr.data = entry_type'(1);
            if (row_ff == nb_ff) begin
               col_in = col_type'(2);
               if (nf_ff > col_type'(1)) begin
                  state_in = ST_FILL_R1;
               end else begin
                  state_in = ST_FINAL;
               end
            end else begin
               row_in = row_ff + row_type'(1);
            end
         end

         // A single ball needs one drop per floor.
         ST_FILL_R1: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = tbl_addr(row_type'(1), col_ff);
            ram_wr.data = DATA_W'(col_ff);
            if (col_ff == nf_ff) begin
               if (nb_ff > row_type'(1)) begin
                  row_in          = row_type'(2);
                  col_in          = col_type'(2);
                  brk_in          = '0;
                  held_in         = col_type'(1);
                  fold_ctrl.clear = 1'b1;
                  state_in        = ST_SCAN;
               end else begin
                  state_in = ST_FINAL;
               end
            end else begin
               col_in = col_ff + col_type'(1);
            end
         end

         // One trial floor per cycle: read both outcomes of the drop.
         ST_SCAN: begin
            ram_rd_a.en   = 1'b1;
            ram_rd_a.addr = tbl_addr(row_ff - row_type'(1), brk_ff);
            ram_rd_b.en   = 1'b1;
            ram_rd_b.addr = tbl_addr(row_ff, held_ff);
            rd_vld_in     = 1'b1;
            if (held_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               brk_in  = brk_ff + col_type'(1);
               held_in = held_ff - col_type'(1);
            end
         end

         // Fold the last trial floor and write the finished entry.
         ST_DRAIN: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = tbl_addr(row_ff, col_ff);
            ram_wr.data = fold_best;
            brk_in      = '0;
            if (col_ff == nf_ff) begin
               if (row_ff == nb_ff) begin
                  state_in = ST_FINAL;
               end else begin
                  row_in          = row_ff + row_type'(1);
                  col_in          = col_type'(2);
                  held_in         = col_type'(1);
                  fold_ctrl.clear = 1'b1;
                  state_in        = ST_SCAN;
               end
            end else begin
               col_in          = col_ff + col_type'(1);
               held_in         = col_ff;
               fold_ctrl.clear = 1'b1;
               state_in        = ST_SCAN;
            end
         end

         // Fetch the answer entry.
         ST_FINAL: begin
            ram_rd_a.en   = 1'b1;
            ram_rd_a.addr = tbl_addr(nb_ff, nf_ff);
            state_in      = ST_FREAD;
         end

         // Hand the answer to the output register once it is free.
         ST_FREAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = zero_ff ? '0 : ram_data_a;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Counters and payload.
   always_ff @(posedge clock) begin
      nb_ff       <= nb_in;
      nf_ff       <= nf_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      brk_ff      <= brk_in;
      held_ff     <= held_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_trials = rsp_data_ff;

endmodule

`default_nettype wire

@@ dv/egg_drop_min_trials_dp_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// egg_drop_min_trials_dp_tb
// Checks the egg drop trial-count engine against a behavioral dynamic-program
// predictor. A short directed list covers the edge sizes, then random queries
// follow, mostly small, with a few at full size. Query bursts, gaps and
// answer stalls are all randomized.
// ---------------------------------------------------------------------------

module egg_drop_min_trials_dp_tb;
   import egg_pkg::*;

   localparam int RANDOM_QUERIES = 80;
   // The watchdog allows several times the run of a full-size query.
   localparam int WATCHDOG_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES    = 64;

   // Keeps the expected answers in query order and checks each answer beat.
   class drop_scoreboard;
      logic [DATA_W-1:0] expected_drops[$];
      logic [DATA_W-1:0] grid[0:MAX_EGGS][0:MAX_FLOORS];
      int queries;
      int answers;
      int errors;

      // Rebuilds the trial table for one query and returns its answer.
      function logic [DATA_W-1:0] predict_drops(logic [IN_BALLS_W-1:0] balls_in,
                                                logic [IN_FLOORS_W-1:0] floors_in);
         int nb, nf, b, f, x, broke, held, worst, best;
         nb = int'(balls_in);
         nf = int'(floors_in);
         if (nb > MAX_EGGS) nb = MAX_EGGS;
         if (nf > MAX_FLOORS) nf = MAX_FLOORS;
         if (nb == 0) return '0;
         for (b = 1; b <= nb; b++) begin
            grid[b][0] = '0;
            if (nf >= 1) grid[b][1] = DATA_W'(1);
         end
         for (f = 1; f <= nf; f++) grid[1][f] = DATA_W'(f);
         for (b = 2; b <= nb; b++) begin
            for (f = 2; f <= nf; f++) begin
               best = 32'h7fff_ffff;
               for (x = 1; x <= f; x++) begin
                  broke = int'(grid[b-1][x-1]);
                  held  = int'(grid[b][f-x]);
                  worst = 1 + ((broke > held) ? broke : held);
                  if (worst < best) best = worst;
               end
               grid[b][f] = best[DATA_W-1:0];
            end
         end
         return grid[nb][nf];
      endfunction

      function void note_query(logic [IN_BALLS_W-1:0] balls_in,
                               logic [IN_FLOORS_W-1:0] floors_in);
         expected_drops.push_back(predict_drops(balls_in, floors_in));
         queries++;
      endfunction

      function int outstanding();
         return expected_drops.size();
      endfunction

      task report_mismatch(input string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_answer(input logic [DATA_W-1:0] got);
         logic [DATA_W-1:0] want;
         answers++;
         if (expected_drops.size() == 0) begin
            report_mismatch($sformatf("answer %0d arrived with no query waiting", got));
         end else begin
            want = expected_drops.pop_front();
            if (got !== want)
               report_mismatch($sformatf("answer %0d: trials %0d, expected %0d",
                                         answers, got, want));
         end
      endtask

      task check_leftovers();
         if (expected_drops.size() != 0)
            report_mismatch($sformatf("%0d answers never arrived",
                                      expected_drops.size()));
      endtask
   endclass

   logic                   clock;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_stall;
   logic [IN_BALLS_W-1:0]  req_balls     = '0;
   logic [IN_FLOORS_W-1:0] req_floors    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall     = 1'b0;
   logic [DATA_W-1:0]      rsp_trials;

   drop_scoreboard sb = new();
   int idle_cycles = 0;
   int burst_left  = 0;
   int big_queries = 0;

   egg_drop_min_trials_dp dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_balls    (req_balls),
      .req_floors   (req_floors),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_trials   (rsp_trials)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Beat monitor and watchdog, sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (req_valid && !req_stall) sb.note_query(req_balls, req_floors);
         if (rsp_valid && !rsp_stall) sb.check_answer(rsp_trials);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Answer stalls: the pattern switches between no stalls, coin flips and
   // long runs of stall and release.
   int stall_mode = 0;
   int mode_age   = 0;
   int run_left   = 0;
   bit run_high   = 1'b0;

   always @(negedge clock) begin
      if (mode_age == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_age   = $urandom_range(50, 400);
      end else begin
         mode_age--;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
         default: begin
            if (run_left == 0) begin
               run_left = $urandom_range(1, 30);
               run_high = ~run_high;
            end
            run_left--;
            rsp_stall <= run_high;
         end
      endcase
   end

   // Idle the query side for some cycles with junk on the payload.
   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid  <= 1'b0;
         req_balls  <= IN_BALLS_W'($urandom);
         req_floors <= IN_FLOORS_W'($urandom);
      end
   endtask

   // Present one query beat and hold it until the block takes it.
   task automatic send_query(input logic [IN_BALLS_W-1:0] balls_in,
                             input logic [IN_FLOORS_W-1:0] floors_in);
      if (burst_left == 0) begin
         idle_sender($urandom_range(0, 6));
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      if (floors_in > 63) big_queries++;
      @(negedge clock);
      req_valid  <= 1'b1;
      req_balls  <= balls_in;
      req_floors <= floors_in;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off new queries until every expected answer has come back.
   task automatic drain_answers();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   // Directed queries: zero and excess balls, zero and one floor, full size.
   localparam int DIRECTED = 20;
   logic [IN_BALLS_W-1:0]  dir_balls[DIRECTED] =
      '{0, 0, 1, 1, 1, 2, 2, 2, 2, 3, 8, 8, 8, 9, 15, 15, 4, 5, 0, 15};
   logic [IN_FLOORS_W-1:0] dir_floors[DIRECTED] =
      '{0, 255, 0, 1, 255, 0, 1, 2, 36, 14, 0, 1, 255, 10, 40, 0, 170, 85, 85, 1};

   initial begin
      logic [IN_BALLS_W-1:0]  balls_pick;
      logic [IN_FLOORS_W-1:0] floors_pick;
      int                     shape;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED; i++) send_query(dir_balls[i], dir_floors[i]);

      // Random queries: mostly small tables, some medium, a few full range.
      for (int i = 0; i < RANDOM_QUERIES; i++) begin
         if (i == RANDOM_QUERIES / 2) drain_answers();
         shape      = $urandom_range(0, 39);
         balls_pick = IN_BALLS_W'($urandom_range(0, 15));
         if (shape == 0) begin
            floors_pick = IN_FLOORS_W'($urandom_range(0, 255));
         end else if (shape < 6) begin
            floors_pick = IN_FLOORS_W'($urandom_range(0, 63));
         end else begin
            floors_pick = IN_FLOORS_W'($urandom_range(0, 31));
         end
         send_query(balls_pick, floors_pick);
      end

      drain_answers();
      repeat (TAIL_CYCLES) @(negedge clock);
      sb.check_leftovers();

      $display("Ran %0d queries (%0d directed, %0d with more than 63 floors).",
               sb.queries, DIRECTED, big_queries);
      $display("Checked %0d answers, %0d mismatches.", sb.answers, sb.errors);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
